// File: hdl/stq_pkg.sv
// Shared types and constants for the sorted timer queue.
`timescale 1ns / 1ps

package stq_pkg;

   localparam int DefaultDepth     = 16;
   localparam int DefaultTimeWidth = 32;
   localparam int IdWidth          = 8;
   localparam int ExpWidth         = 32;
   localparam int MaxResults       = 16;
   localparam int NpopWidth        = $clog2(MaxResults + 1);

   typedef enum logic [1:0] {
      FuncAdd,
      FuncDelete,
      FuncAdjust,
      FuncTick
   } func_type;

   typedef enum logic [2:0] {
      StatusDone,
      StatusExpired,
      StatusFull,
      StatusNotFound,
      StatusNone,
      StatusDup
   } status_type;

   typedef enum logic [2:0] {
      StIdle,
      StScan,
      StShiftDn,
      StShiftUp,
      StTickHead,
      StTickCmp
   } state_type;

endpackage

// File: hdl/sorted_timer_queue_unit.sv
// Sorted timer queue: timers kept in expiry order in a table with one read and one write port.
// Add and delete scan the table and then shift it; adjust scans, shifts down, scans and shifts up;
// tick reads the head and pops expired items from it one by one.
// One item at a time: busy falls in the cycle that carries the last result.
// Results leave on rsp_strobe for one cycle each; the receiver cannot stall.
// Reset clears the entry count and the controller; the table is not cleared.
`timescale 1ns / 1ps

module sorted_timer_queue_unit #(
   parameter int DEPTH      = stq_pkg::DefaultDepth,
   parameter int TIME_WIDTH = stq_pkg::DefaultTimeWidth
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_func,
   input  logic [stq_pkg::IdWidth-1:0]  req_timer_id,
   input  logic [stq_pkg::ExpWidth-1:0] req_expire_time,
   input  logic [stq_pkg::ExpWidth-1:0] req_now,
   output logic                         rsp_strobe,
   output logic [2:0]                   rsp_status,
   output logic [stq_pkg::IdWidth-1:0]  rsp_timer_id_res,
   output logic [stq_pkg::ExpWidth-1:0] rsp_expire_time_res,
   output logic                         rsp_last
);

   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int IW   = stq_pkg::IdWidth;
   localparam int ExpW = stq_pkg::ExpWidth;
   localparam int NW   = stq_pkg::NpopWidth;

   logic [TIME_WIDTH-1:0] exp_mem_ff [DEPTH];
   logic [IW-1:0]         id_mem_ff  [DEPTH];

   stq_pkg::state_type  state_ff, state_in;
   stq_pkg::func_type   op_ff, op_in;
   stq_pkg::status_type rsp_status_ff, rsp_status_in;

   logic [IW-1:0]         id_ff, id_in;
   logic [TIME_WIDTH-1:0] exp_ff, exp_in;
   logic [TIME_WIDTH-1:0] now_ff, now_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [CW-1:0]         ptr_ff, ptr_in;
   logic                  rv_ff, rv_in;
   logic [CW-1:0]         rptr_ff, rptr_in;
   logic                  hit_ff, hit_in;
   logic [CW-1:0]         hit_pos_ff, hit_pos_in;
   logic [TIME_WIDTH-1:0] hit_exp_ff, hit_exp_in;
   logic                  pos_set_ff, pos_set_in;
   logic [CW-1:0]         pos_ff, pos_in;
   logic                  phase_ff, phase_in;
   logic [NW-1:0]         npop_ff, npop_in;
   logic                  pend_ff, pend_in;
   logic [IW-1:0]         pend_id_ff, pend_id_in;
   logic [TIME_WIDTH-1:0] pend_exp_ff, pend_exp_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   logic [IW-1:0]         rsp_id_ff, rsp_id_in;
   logic [TIME_WIDTH-1:0] rsp_exp_ff, rsp_exp_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic [TIME_WIDTH-1:0] rd_exp_ff;
   logic [IW-1:0]         rd_id_ff;

   logic                  rd_en;
   logic [AW-1:0]         raddr;
   logic                  we;
   logic [AW-1:0]         waddr;
   logic [TIME_WIDTH-1:0] wexp;
   logic [IW-1:0]         wid;

   logic [CW-1:0] ptr_inc, ptr_dec, rptr_inc, rptr_dec, hit_pos_inc;
   logic          accept, reads_left, scan_done, up_done, expired, tick_stop, full;

   assign ptr_inc     = ptr_ff + CW'(1);
   assign ptr_dec     = ptr_ff - CW'(1);
   assign rptr_inc    = rptr_ff + CW'(1);
   assign rptr_dec    = rptr_ff - CW'(1);
   assign hit_pos_inc = hit_pos_ff + CW'(1);

   assign accept     = start && (state_ff == stq_pkg::StIdle);
   assign reads_left = ptr_ff < cnt_ff;
   assign scan_done  = !reads_left && !rv_ff;
   assign up_done    = !(ptr_ff > pos_ff) && !rv_ff;
   assign expired    = !(now_ff < rd_exp_ff);
   assign tick_stop  = (cnt_ff == '0) || (npop_ff == NW'(stq_pkg::MaxResults));
   assign full       = cnt_ff == CW'(DEPTH);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         stq_pkg::StIdle: begin
            if (start) begin
               if (stq_pkg::func_type'(req_func) == stq_pkg::FuncTick) begin
                  state_in = stq_pkg::StTickHead;
               end else begin
                  state_in = stq_pkg::StScan;
               end
            end
         end
         stq_pkg::StScan: begin
            if (scan_done) begin
               if (phase_ff) begin
                  state_in = stq_pkg::StShiftUp;
               end else if (op_ff == stq_pkg::FuncAdd) begin
                  state_in = (hit_ff || full) ? stq_pkg::StIdle : stq_pkg::StShiftUp;
               end else begin
                  state_in = hit_ff ? stq_pkg::StShiftDn : stq_pkg::StIdle;
               end
            end
         end
         stq_pkg::StShiftDn: begin
            if (scan_done) begin
               case (op_ff)
                  stq_pkg::FuncTick:   state_in = stq_pkg::StTickHead;
                  stq_pkg::FuncAdjust: state_in = stq_pkg::StScan;
                  default:             state_in = stq_pkg::StIdle;
               endcase
            end
         end
         stq_pkg::StShiftUp: begin
            if (up_done) begin
               state_in = stq_pkg::StIdle;
            end
         end
         stq_pkg::StTickHead: begin
            state_in = tick_stop ? stq_pkg::StIdle : stq_pkg::StTickCmp;
         end
         stq_pkg::StTickCmp: begin
            state_in = expired ? stq_pkg::StShiftDn : stq_pkg::StIdle;
         end
         default: state_in = stq_pkg::StIdle;
      endcase
   end

   // datapath and outputs
   always_comb begin
      op_in         = op_ff;
      id_in         = id_ff;
      exp_in        = exp_ff;
      now_in        = now_ff;
      cnt_in        = cnt_ff;
      ptr_in        = ptr_ff;
      rv_in         = 1'b0;
      rptr_in       = rptr_ff;
      hit_in        = hit_ff;
      hit_pos_in    = hit_pos_ff;
      hit_exp_in    = hit_exp_ff;
      pos_set_in    = pos_set_ff;
      pos_in        = pos_ff;
      phase_in      = phase_ff;
      npop_in       = npop_ff;
      pend_in       = pend_ff;
      pend_id_in    = pend_id_ff;
      pend_exp_in   = pend_exp_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_exp_in    = rsp_exp_ff;
      rsp_last_in   = rsp_last_ff;
      rd_en         = 1'b0;
      raddr         = ptr_ff[AW-1:0];
      we            = 1'b0;
      waddr         = rptr_ff[AW-1:0];
      wexp          = rd_exp_ff;
      wid           = rd_id_ff;
      case (state_ff)
         stq_pkg::StIdle: begin
            if (accept) begin
               op_in      = stq_pkg::func_type'(req_func);
               id_in      = req_timer_id;
               exp_in     = TIME_WIDTH'(req_expire_time);
               now_in     = TIME_WIDTH'(req_now);
               ptr_in     = '0;
               hit_in     = 1'b0;
               pos_set_in = 1'b0;
               phase_in   = 1'b0;
               npop_in    = '0;
               pend_in    = 1'b0;
            end
         end
         stq_pkg::StScan: begin
            if (reads_left) begin
               rd_en   = 1'b1;
               raddr   = ptr_ff[AW-1:0];
               rv_in   = 1'b1;
               rptr_in = ptr_ff;
               ptr_in  = ptr_inc;
            end
            if (rv_ff) begin
               if (rd_id_ff == id_ff && !hit_ff) begin
                  hit_in     = 1'b1;
                  hit_pos_in = rptr_ff;
                  hit_exp_in = rd_exp_ff;
               end
               if (rptr_ff == '0) begin
                  if (exp_ff < rd_exp_ff) begin
                     pos_set_in = 1'b1;
                     pos_in     = '0;
                  end
               end else if (!pos_set_ff && !(rd_exp_ff < exp_ff)) begin
                  pos_set_in = 1'b1;
                  pos_in     = rptr_ff;
               end
            end
            if (scan_done) begin
               pos_in = pos_set_ff ? pos_ff : cnt_ff;
               ptr_in = cnt_ff;
               rsp_id_in   = id_ff;
               rsp_last_in = 1'b1;
               if (!phase_ff) begin
                  if (op_ff == stq_pkg::FuncAdd) begin
                     if (hit_ff) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = stq_pkg::StatusDup;
                        rsp_exp_in    = hit_exp_ff;
                     end else if (full) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = stq_pkg::StatusFull;
                        rsp_exp_in    = '0;
                     end
                  end else if (!hit_ff) begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = stq_pkg::StatusNotFound;
                     rsp_exp_in    = '0;
                  end else begin
                     ptr_in = hit_pos_inc;
                  end
               end
            end
         end
         stq_pkg::StShiftDn: begin
            if (reads_left) begin
               rd_en   = 1'b1;
               raddr   = ptr_ff[AW-1:0];
               rv_in   = 1'b1;
               rptr_in = ptr_ff;
               ptr_in  = ptr_inc;
            end
            if (rv_ff) begin
               we    = 1'b1;
               waddr = rptr_dec[AW-1:0];
            end
            if (scan_done) begin
               cnt_in = cnt_ff - CW'(1);
               if (op_ff == stq_pkg::FuncDelete) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = stq_pkg::StatusDone;
                  rsp_id_in     = id_ff;
                  rsp_exp_in    = hit_exp_ff;
                  rsp_last_in   = 1'b1;
               end else if (op_ff == stq_pkg::FuncAdjust) begin
                  ptr_in     = '0;
                  pos_set_in = 1'b0;
                  phase_in   = 1'b1;
               end
            end
         end
         stq_pkg::StShiftUp: begin
            if (ptr_ff > pos_ff) begin
               rd_en   = 1'b1;
               raddr   = ptr_dec[AW-1:0];
               rv_in   = 1'b1;
               rptr_in = ptr_dec;
               ptr_in  = ptr_dec;
            end
            if (rv_ff) begin
               we    = 1'b1;
               waddr = rptr_inc[AW-1:0];
            end
            if (up_done) begin
               we            = 1'b1;
               waddr         = pos_ff[AW-1:0];
               wexp          = exp_ff;
               wid           = id_ff;
               cnt_in        = cnt_ff + CW'(1);
               rsp_strobe_in = 1'b1;
               rsp_status_in = stq_pkg::StatusDone;
               rsp_id_in     = id_ff;
               rsp_exp_in    = exp_ff;
               rsp_last_in   = 1'b1;
            end
         end
         stq_pkg::StTickHead: begin
            if (tick_stop) begin
               rsp_strobe_in = 1'b1;
               rsp_last_in   = 1'b1;
               rsp_status_in = pend_ff ? stq_pkg::StatusExpired : stq_pkg::StatusNone;
               rsp_id_in     = pend_ff ? pend_id_ff : '0;
               rsp_exp_in    = pend_ff ? pend_exp_ff : '0;
            end else begin
               rd_en = 1'b1;
               raddr = '0;
            end
         end
         stq_pkg::StTickCmp: begin
            rsp_status_in = pend_ff ? stq_pkg::StatusExpired : stq_pkg::StatusNone;
            rsp_id_in     = pend_ff ? pend_id_ff : '0;
            rsp_exp_in    = pend_ff ? pend_exp_ff : '0;
            if (expired) begin
               rsp_strobe_in = pend_ff;
               rsp_last_in   = 1'b0;
               pend_in       = 1'b1;
               pend_id_in    = rd_id_ff;
               pend_exp_in   = rd_exp_ff;
               npop_in       = npop_ff + NW'(1);
               ptr_in        = CW'(1);
            end else begin
               rsp_strobe_in = 1'b1;
               rsp_last_in   = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= stq_pkg::StIdle;
         cnt_ff        <= '0;
         rv_ff         <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         rv_ff         <= rv_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      id_ff         <= id_in;
      exp_ff        <= exp_in;
      now_ff        <= now_in;
      ptr_ff        <= ptr_in;
      rptr_ff       <= rptr_in;
      hit_ff        <= hit_in;
      hit_pos_ff    <= hit_pos_in;
      hit_exp_ff    <= hit_exp_in;
      pos_set_ff    <= pos_set_in;
      pos_ff        <= pos_in;
      phase_ff      <= phase_in;
      npop_ff       <= npop_in;
      pend_ff       <= pend_in;
      pend_id_ff    <= pend_id_in;
      pend_exp_ff   <= pend_exp_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_exp_ff    <= rsp_exp_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         exp_mem_ff[waddr] <= wexp;
         id_mem_ff[waddr]  <= wid;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_exp_ff <= exp_mem_ff[raddr];
         rd_id_ff  <= id_mem_ff[raddr];
      end
   end

   assign busy                = state_ff != stq_pkg::StIdle;
   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_timer_id_res    = rsp_id_ff;
   assign rsp_expire_time_res = ExpW'(rsp_exp_ff);
   assign rsp_last            = rsp_last_ff;

endmodule

// File: dv/stq_checker.sv
// Checker for the sorted timer queue: shadows the timer table, predicts each report, compares.
`timescale 1ns / 1ps

module stq_checker #(
   parameter int DEPTH = stq_pkg::DefaultDepth
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         busy,
   input  logic [1:0]                   req_func,
   input  logic [stq_pkg::IdWidth-1:0]  req_timer_id,
   input  logic [stq_pkg::ExpWidth-1:0] req_expire_time,
   input  logic [stq_pkg::ExpWidth-1:0] req_now,
   input  logic                         rsp_strobe,
   input  logic [2:0]                   rsp_status,
   input  logic [stq_pkg::IdWidth-1:0]  rsp_timer_id_res,
   input  logic [stq_pkg::ExpWidth-1:0] rsp_expire_time_res,
   input  logic                         rsp_last,
   output int                           fail_count,
   output int                           pending_count
);

   typedef struct packed {
      stq_pkg::status_type          status;
      logic [stq_pkg::IdWidth-1:0]  timer_id;
      logic [stq_pkg::ExpWidth-1:0] expiry;
      logic                         last;
   } timer_report_type;

   logic [stq_pkg::ExpWidth-1:0] shadow_expiry [DEPTH];
   logic [stq_pkg::IdWidth-1:0]  shadow_id     [DEPTH];
   int                           shadow_count;
   timer_report_type             due_reports   [$];

   task automatic report_mismatch(string msg);
      $display("ERROR %0t: %s", $realtime, msg);
      fail_count++;
   endtask

   function automatic void post_report(stq_pkg::status_type st,
                                       logic [stq_pkg::IdWidth-1:0] id,
                                       logic [stq_pkg::ExpWidth-1:0] expiry, logic last);
      timer_report_type r;
      r.status   = st;
      r.timer_id = id;
      r.expiry   = expiry;
      r.last     = last;
      due_reports.push_back(r);
   endfunction

   function automatic int find_timer(logic [stq_pkg::IdWidth-1:0] id);
      for (int i = 0; i < shadow_count; i++) begin
         if (shadow_id[i] == id) return i;
      end
      return -1;
   endfunction

   function automatic void remove_timer(int pos);
      for (int i = pos; i + 1 < shadow_count; i++) begin
         shadow_expiry[i] = shadow_expiry[i + 1];
         shadow_id[i]     = shadow_id[i + 1];
      end
      if (shadow_count > 0) shadow_count--;
   endfunction

   function automatic void insert_timer(logic [stq_pkg::IdWidth-1:0] id,
                                        logic [stq_pkg::ExpWidth-1:0] expiry);
      int pos;
      pos = 0;
      if (shadow_count > 0 && !(expiry < shadow_expiry[0])) begin
         pos = 1;
         while (pos < shadow_count && shadow_expiry[pos] < expiry) pos++;
      end
      for (int i = shadow_count; i > pos; i--) begin
         shadow_expiry[i] = shadow_expiry[i - 1];
         shadow_id[i]     = shadow_id[i - 1];
      end
      shadow_expiry[pos] = expiry;
      shadow_id[pos]     = id;
      shadow_count++;
   endfunction

   function automatic logic head_due(logic [stq_pkg::ExpWidth-1:0] tnow, int popped);
      return popped < stq_pkg::MaxResults && shadow_count > 0 && !(tnow < shadow_expiry[0]);
   endfunction

   task automatic apply_timer_op(logic [1:0] op, logic [stq_pkg::IdWidth-1:0] id,
                                 logic [stq_pkg::ExpWidth-1:0] expiry,
                                 logic [stq_pkg::ExpWidth-1:0] tnow);
      int                           pos;
      int                           popped;
      logic [stq_pkg::IdWidth-1:0]  head_id;
      logic [stq_pkg::ExpWidth-1:0] old_expiry;
      pos = find_timer(id);
      case (stq_pkg::func_type'(op))
         stq_pkg::FuncAdd: begin
            if (pos >= 0) begin
               post_report(stq_pkg::StatusDup, id, shadow_expiry[pos], 1'b1);
            end else if (shadow_count >= DEPTH) begin
               post_report(stq_pkg::StatusFull, id, '0, 1'b1);
            end else begin
               insert_timer(id, expiry);
               post_report(stq_pkg::StatusDone, id, expiry, 1'b1);
            end
         end
         stq_pkg::FuncDelete, stq_pkg::FuncAdjust: begin
            if (pos < 0) begin
               post_report(stq_pkg::StatusNotFound, id, '0, 1'b1);
            end else begin
               old_expiry = shadow_expiry[pos];
               remove_timer(pos);
               if (stq_pkg::func_type'(op) == stq_pkg::FuncAdjust) begin
                  insert_timer(id, expiry);
                  post_report(stq_pkg::StatusDone, id, expiry, 1'b1);
               end else begin
                  post_report(stq_pkg::StatusDone, id, old_expiry, 1'b1);
               end
            end
         end
         default: begin
            popped = 0;
            if (!head_due(tnow, popped)) begin
               post_report(stq_pkg::StatusNone, '0, '0, 1'b1);
            end
            while (head_due(tnow, popped)) begin
               head_id    = shadow_id[0];
               old_expiry = shadow_expiry[0];
               remove_timer(0);
               popped++;
               post_report(stq_pkg::StatusExpired, head_id, old_expiry,
                           !head_due(tnow, popped));
            end
         end
      endcase
   endtask

   task automatic check_report();
      timer_report_type want;
      if (due_reports.size() == 0) begin
         report_mismatch($sformatf("unexpected report: status %0d id %0d expiry %0h last %0b",
                                   rsp_status, rsp_timer_id_res, rsp_expire_time_res,
                                   rsp_last));
         return;
      end
      want = due_reports.pop_front();
      if (rsp_status !== want.status)
         report_mismatch($sformatf("status: got %0d, want %0d", rsp_status, want.status));
      if (rsp_timer_id_res !== want.timer_id)
         report_mismatch($sformatf("timer id: got %0d, want %0d", rsp_timer_id_res,
                                   want.timer_id));
      if (rsp_expire_time_res !== want.expiry)
         report_mismatch($sformatf("expiry: got %0h, want %0h", rsp_expire_time_res,
                                   want.expiry));
      if (rsp_last !== want.last)
         report_mismatch($sformatf("last: got %0b, want %0b", rsp_last, want.last));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         shadow_count = 0;
         fail_count   = 0;
         due_reports.delete();
      end else begin
         if (rsp_strobe) check_report();
         if (start && !busy) apply_timer_op(req_func, req_timer_id, req_expire_time, req_now);
      end
      pending_count <= due_reports.size();
   end

endmodule

// File: dv/tb_sorted_timer_queue_unit.sv
// Testbench top for the sorted timer queue: drives timer operations and gives the verdict.
`timescale 1ns / 1ps

module tb_sorted_timer_queue_unit;

   localparam int Depth       = stq_pkg::DefaultDepth;
   localparam int RandomItems = 400;
   localparam int CalmItems   = 60;
   localparam int DrainCycles = 400;
   localparam int CycleLimit  = 1000000;

   logic                         clock           = 1'b0;
   logic                         reset           = 1'b1;
   logic                         start           = 1'b0;
   logic [1:0]                   req_func        = stq_pkg::FuncTick;
   logic [stq_pkg::IdWidth-1:0]  req_timer_id    = '0;
   logic [stq_pkg::ExpWidth-1:0] req_expire_time = '0;
   logic [stq_pkg::ExpWidth-1:0] req_now         = '0;
   logic                         busy;
   logic                         rsp_strobe;
   logic [2:0]                   rsp_status;
   logic [stq_pkg::IdWidth-1:0]  rsp_timer_id_res;
   logic [stq_pkg::ExpWidth-1:0] rsp_expire_time_res;
   logic                         rsp_last;
   int                           fail_count;
   int                           pending_count;
   int                           cycle_count     = 0;

   sorted_timer_queue_unit #(
      .DEPTH      (Depth),
      .TIME_WIDTH (stq_pkg::DefaultTimeWidth)
   ) i_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_func            (req_func),
      .req_timer_id        (req_timer_id),
      .req_expire_time     (req_expire_time),
      .req_now             (req_now),
      .rsp_strobe          (rsp_strobe),
      .rsp_status          (rsp_status),
      .rsp_timer_id_res    (rsp_timer_id_res),
      .rsp_expire_time_res (rsp_expire_time_res),
      .rsp_last            (rsp_last)
   );

   stq_checker #(
      .DEPTH (Depth)
   ) i_checker (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_func            (req_func),
      .req_timer_id        (req_timer_id),
      .req_expire_time     (req_expire_time),
      .req_now             (req_now),
      .rsp_strobe          (rsp_strobe),
      .rsp_status          (rsp_status),
      .rsp_timer_id_res    (rsp_timer_id_res),
      .rsp_expire_time_res (rsp_expire_time_res),
      .rsp_last            (rsp_last),
      .fail_count          (fail_count),
      .pending_count       (pending_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("tb_sorted_timer_queue_unit NOT OK");
         $finish;
      end
   end

   task automatic send_op(stq_pkg::func_type op, logic [stq_pkg::IdWidth-1:0] id,
                          logic [stq_pkg::ExpWidth-1:0] expiry,
                          logic [stq_pkg::ExpWidth-1:0] tnow);
      req_func        <= op;
      req_timer_id    <= id;
      req_expire_time <= expiry;
      req_now         <= tnow;
      start           <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic hold_sender(int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain_reports();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      logic [stq_pkg::ExpWidth-1:0] base_time;
      logic [stq_pkg::ExpWidth-1:0] expiry;
      logic [stq_pkg::ExpWidth-1:0] tnow;
      logic [stq_pkg::IdWidth-1:0]  id;
      int                           pick;
      stq_pkg::func_type            op;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_op(stq_pkg::FuncTick,   8'd0,   '0, '0);
      send_op(stq_pkg::FuncDelete, 8'd0,   '0, '0);
      send_op(stq_pkg::FuncAdjust, 8'd255, 32'hFFFF_FFFF, '0);
      send_op(stq_pkg::FuncAdd,    8'd0,   32'd100, '0);
      send_op(stq_pkg::FuncAdd,    8'd255, 32'd100, '0);
      send_op(stq_pkg::FuncAdd,    8'd1,   32'd100, '0);
      send_op(stq_pkg::FuncAdd,    8'd2,   32'd50, '0);
      send_op(stq_pkg::FuncAdd,    8'd3,   32'hFFFF_FFFF, '0);
      send_op(stq_pkg::FuncAdd,    8'd4,   32'd0, '0);
      send_op(stq_pkg::FuncAdd,    8'd0,   32'd7, '0);
      send_op(stq_pkg::FuncAdjust, 8'd3,   32'd200, '0);
      send_op(stq_pkg::FuncAdjust, 8'd4,   32'd150, '0);
      send_op(stq_pkg::FuncDelete, 8'd2,   '0, '0);
      for (int k = 0; k < Depth - 5; k++) begin
         send_op(stq_pkg::FuncAdd, 8'(8'hA0 + k), 32'(k * 40), '0);
      end
      send_op(stq_pkg::FuncAdd,  8'hAA, 32'd1, '0);
      send_op(stq_pkg::FuncTick, 8'd0, '0, 32'd120);
      send_op(stq_pkg::FuncTick, 8'd0, '0, 32'hFFFF_FFFF);
      send_op(stq_pkg::FuncTick, 8'd0, '0, 32'hFFFF_FFFF);
      drain_reports();

      base_time = 32'd1000;
      for (int n = 0; n < RandomItems; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 40)      op = stq_pkg::FuncAdd;
         else if (pick < 55) op = stq_pkg::FuncDelete;
         else if (pick < 75) op = stq_pkg::FuncAdjust;
         else                op = stq_pkg::FuncTick;
         id     = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 19));
         expiry = ($urandom_range(0, 9) == 0) ? $urandom
                                              : base_time + 32'($urandom_range(0, 12) * 8);
         tnow   = ($urandom_range(0, 9) == 0) ? $urandom : base_time;
         base_time = base_time + 32'($urandom_range(0, 40));
         send_op(op, id, expiry, tnow);
         if (n == RandomItems / 2) begin
            drain_reports();
         end else if (n < RandomItems - CalmItems && $urandom_range(0, 3) == 0) begin
            hold_sender($urandom_range(1, 15));
         end
      end

      drain_reports();
      repeat (DrainCycles) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_sorted_timer_queue_unit OK");
      end else begin
         $display("tb_sorted_timer_queue_unit NOT OK");
      end
      $finish;
   end

endmodule

// File: files.f
hdl/stq_pkg.sv
hdl/sorted_timer_queue_unit.sv
dv/stq_checker.sv
dv/tb_sorted_timer_queue_unit.sv
